// ===== rtl/core/trial_division_prime_test_top_macros.svh =====
// Assertion macros for the trial division prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDP_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDP_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/tdp_pkg.sv =====
// Shared constants and control and status types of the trial division prime test block.
package tdp_pkg;

	localparam int NUM_W    = 32;
	localparam int CAND_W   = 32;
	localparam int FACTOR_W = 16;
	localparam int DIV_W    = NUM_W / 2 + 1;
	localparam int SQ_W     = NUM_W + 1;
	localparam int CNT_W    = $clog2(NUM_W);

	localparam int DIV_FIRST = 3;
	localparam int DIV_STEP  = 2;
	localparam int EVEN_PRIME = 2;

	typedef struct packed {
		logic div_init;
		logic div_advance;
		logic rem_load;
	} ctrl_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_sts_t;

endpackage

// ===== rtl/core/trial_division_prime_test_top.sv =====
// Top level of the trial division prime test block.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------
//  input    | start & !busy      | candidate[31:0]
//  result   | done (one cycle)   | is_prime, smallest_factor[15:0]
//
// Negative values, 0, 1, 2 and even values: result in the cycle after transfer.
// Odd values: for each odd trial divisor, one bound check plus the bit-serial
// remainder unit (one quotient bit per cycle), then, for a prime, one final bound
// check, and then the registered result.
// Reset clears control state asynchronously; no memory, no clearing pass.
// The receiver cannot stall: done pulses once per item, busy stays low while idle.
module trial_division_prime_test_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tdp_pkg::CAND_W-1:0]    candidate,
	output logic                          busy,
	output logic                          done,
	output logic                          is_prime,
	output logic [tdp_pkg::FACTOR_W-1:0]  smallest_factor
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_BOUND  = 3'b010,
		ST_DIVIDE = 3'b100
	} state_t;

	state_t                        state_q;
	state_t                        state_nxt;
	logic [tdp_pkg::NUM_W-1:0]     n_q;
	logic [tdp_pkg::NUM_W-1:0]     n_in;
	logic                          done_q;
	logic                          prime_q;
	logic [tdp_pkg::FACTOR_W-1:0]  factor_q;
	logic                          emit;
	logic                          emit_prime;
	logic [tdp_pkg::FACTOR_W-1:0]  emit_factor;
	logic                          accept;
	tdp_pkg::ctrl_t                ctrl;
	tdp_pkg::rem_sts_t             rem_sts;
	logic [tdp_pkg::DIV_W-1:0]     divisor;
	logic                          in_range;

	assign n_in   = tdp_pkg::NUM_W'($unsigned(candidate));
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_nxt        = state_q;
		ctrl             = '0;
		emit             = 1'b0;
		emit_prime       = 1'b0;
		emit_factor      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (n_in[tdp_pkg::NUM_W-1] || (n_in < tdp_pkg::NUM_W'(2))) begin
						emit = 1'b1;
					end else if (n_in == tdp_pkg::NUM_W'(tdp_pkg::EVEN_PRIME)) begin
						emit       = 1'b1;
						emit_prime = 1'b1;
					end else if (!n_in[0]) begin
						emit        = 1'b1;
						emit_factor = tdp_pkg::FACTOR_W'(tdp_pkg::EVEN_PRIME);
					end else begin
						ctrl.div_init = 1'b1;
						state_nxt     = ST_BOUND;
					end
				end
			end
			ST_BOUND: begin
				if (in_range) begin
					ctrl.rem_load = 1'b1;
					state_nxt     = ST_DIVIDE;
				end else begin
					emit       = 1'b1;
					emit_prime = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (rem_sts.done) begin
					if (rem_sts.zero) begin
						emit        = 1'b1;
						emit_factor = tdp_pkg::FACTOR_W'(divisor);
						state_nxt   = ST_IDLE;
					end else begin
						ctrl.div_advance = 1'b1;
						state_nxt        = ST_BOUND;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_in;
		end
		if (emit) begin
			prime_q  <= emit_prime;
			factor_q <= emit_factor;
		end
	end

	tdp_div_gen u_div_gen (
		.clk      (clk),
		.ctrl     (ctrl),
		.number   (n_q),
		.divisor  (divisor),
		.in_range (in_range)
	);

	tdp_rem_unit u_rem_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.number  (n_q),
		.divisor (divisor),
		.sts     (rem_sts)
	);

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign is_prime        = prime_q;
	assign smallest_factor = factor_q;

endmodule

// ===== rtl/core/tdp_rem_unit.sv =====
// Bit-serial remainder unit: one quotient bit per cycle, flags a zero remainder.
module tdp_rem_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tdp_pkg::ctrl_t             ctrl,
	input  logic [tdp_pkg::NUM_W-1:0]  number,
	input  logic [tdp_pkg::DIV_W-1:0]  divisor,
	output tdp_pkg::rem_sts_t          sts
);

	logic [tdp_pkg::NUM_W-1:0] nsh_q;
	logic [tdp_pkg::DIV_W-1:0] rem_q;
	logic [tdp_pkg::CNT_W-1:0] cnt_q;
	logic                      run_q;

	logic [tdp_pkg::DIV_W:0]   trial;
	logic [tdp_pkg::DIV_W+1:0] diff;
	logic [tdp_pkg::DIV_W-1:0] rem_nxt;

	assign trial   = {rem_q, nsh_q[tdp_pkg::NUM_W-1]};
	assign diff    = {1'b0, trial} - {2'b00, divisor};
	assign rem_nxt = diff[tdp_pkg::DIV_W+1] ? trial[tdp_pkg::DIV_W-1:0]
	                                        : diff[tdp_pkg::DIV_W-1:0];

	assign sts.done = run_q && (cnt_q == '0);
	assign sts.zero = (rem_nxt == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.rem_load) begin
			run_q <= 1'b1;
			cnt_q <= tdp_pkg::CNT_W'(tdp_pkg::NUM_W - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - tdp_pkg::CNT_W'(1);
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rem_load) begin
			nsh_q <= number;
			rem_q <= '0;
		end else if (run_q) begin
			nsh_q <= {nsh_q[tdp_pkg::NUM_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== rtl/core/tdp_div_gen.sv =====
// Odd divisor generator with its running square for the bound test.
module tdp_div_gen (
	input  logic                       clk,
	input  tdp_pkg::ctrl_t             ctrl,
	input  logic [tdp_pkg::NUM_W-1:0]  number,
	output logic [tdp_pkg::DIV_W-1:0]  divisor,
	output logic                       in_range
);

	logic [tdp_pkg::DIV_W-1:0] d_q;
	logic [tdp_pkg::SQ_W-1:0]  sq_q;

	assign divisor  = d_q;
	assign in_range = (sq_q <= tdp_pkg::SQ_W'(number));

	// (d + 2)^2 = d^2 + 4d + 4
	always_ff @(posedge clk) begin
		if (ctrl.div_init) begin
			d_q  <= tdp_pkg::DIV_W'(tdp_pkg::DIV_FIRST);
			sq_q <= tdp_pkg::SQ_W'(tdp_pkg::DIV_FIRST * tdp_pkg::DIV_FIRST);
		end else if (ctrl.div_advance) begin
			d_q  <= d_q + tdp_pkg::DIV_W'(tdp_pkg::DIV_STEP);
			sq_q <= sq_q + tdp_pkg::SQ_W'({d_q, 2'b00})
			        + tdp_pkg::SQ_W'(tdp_pkg::DIV_STEP * tdp_pkg::DIV_STEP);
		end
	end

endmodule

// ===== rtl/core/tdp_checker.sv =====
// Port-level checker for the trial division prime test block, with its bind.
`include "trial_division_prime_test_top_macros.svh"

module tdp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          is_prime,
	input logic [tdp_pkg::FACTOR_W-1:0]  smallest_factor
);

	`TDP_ASSERT_NEXT(a_transfer_answered, start && !busy, done || busy, "transfer left no work or result")
	`TDP_ASSERT_SAME(a_done_not_busy, done, !busy, "result shown while busy")
	`TDP_ASSERT_SAME(a_busy_ends_in_result, $fell(busy), done, "busy dropped without a result")
	`TDP_ASSERT_SAME(a_prime_no_factor, done && is_prime, smallest_factor == '0, "prime with a factor")

endmodule

bind trial_division_prime_test_top tdp_checker u_tdp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.is_prime        (is_prime),
	.smallest_factor (smallest_factor)
);

// ===== dv/trial_division_prime_test_top_test.sv =====
// Self-checking testbench for the trial division prime test block: driver, monitor, predictor.
`timescale 1ns / 1ps

module trial_division_prime_test_top_test;

	localparam int STALL_LIMIT   = 400_000;
	localparam int DRAIN_CYCLES  = 64;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_ITEMS  = 100;

	typedef struct {
		logic [tdp_pkg::CAND_W-1:0] value;
		int unsigned                gap_pct;
	} candidate_item_t;

	typedef struct {
		logic [tdp_pkg::CAND_W-1:0]   value;
		logic                         is_prime;
		logic [tdp_pkg::FACTOR_W-1:0] factor;
	} verdict_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [tdp_pkg::CAND_W-1:0]   candidate = '0;
	logic                         busy;
	logic                         done;
	logic                         is_prime;
	logic [tdp_pkg::FACTOR_W-1:0] smallest_factor;

	candidate_item_t pending_candidates [$];
	verdict_t        expected_verdicts [$];

	int fault_count = 0;
	int primes_seen = 0;
	int others_seen = 0;
	int idle_cycles = 0;

	trial_division_prime_test_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.candidate       (candidate),
		.busy            (busy),
		.done            (done),
		.is_prime        (is_prime),
		.smallest_factor (smallest_factor)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic verdict_t judge_candidate(input logic [tdp_pkg::CAND_W-1:0] value);
		logic [63:0] n;
		logic [63:0] d;
		verdict_t    v;
		n = 64'(value);
		if (tdp_pkg::NUM_W < 64) begin
			n = n & ((64'd1 << tdp_pkg::NUM_W) - 64'd1);
		end
		v.value    = value;
		v.is_prime = 1'b0;
		v.factor   = '0;
		if (n[tdp_pkg::NUM_W-1] || n < 64'd2) begin
			return v;
		end
		if (n == 64'(tdp_pkg::EVEN_PRIME)) begin
			v.is_prime = 1'b1;
			return v;
		end
		if (!n[0]) begin
			v.factor = tdp_pkg::FACTOR_W'(tdp_pkg::EVEN_PRIME);
			return v;
		end
		for (d = 64'(tdp_pkg::DIV_FIRST); d <= n / d; d += 64'(tdp_pkg::DIV_STEP)) begin
			if (n % d == 64'd0) begin
				v.factor = d[tdp_pkg::FACTOR_W-1:0];
				return v;
			end
		end
		v.is_prime = 1'b1;
		return v;
	endfunction

	function automatic logic [tdp_pkg::CAND_W-1:0] draw_candidate();
		int unsigned                pick;
		logic [tdp_pkg::CAND_W-1:0] a;
		logic [tdp_pkg::CAND_W-1:0] b;
		pick = $urandom_range(99);
		if (pick < 12) begin
			return 32'h8000_0000 | $urandom();
		end else if (pick < 24) begin
			return $urandom() & ~32'd1;
		end else if (pick < 30) begin
			return $urandom_range(8);
		end else if (pick < 62) begin
			return $urandom_range(65535) | 32'd1;
		end else if (pick < 78) begin
			return $urandom_range(1_048_575) | 32'd1;
		end
		// odd product with a small odd factor keeps the search short
		a = $urandom_range(49) * 2 + 3;
		b = $urandom_range(32'h7FFF_FFFF / 101) | 32'd1;
		return a * b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		candidate_item_t next_item;
		if (!arst_n) begin
			start     <= 1'b0;
			candidate <= '0;
		end else begin
			if (start && !busy) begin
				expected_verdicts.push_back(judge_candidate(candidate));
			end
			if (!start || !busy) begin
				if (pending_candidates.size() != 0 &&
						$urandom_range(99) >= pending_candidates[0].gap_pct) begin
					next_item = pending_candidates.pop_front();
					start     <= 1'b1;
					candidate <= next_item.value;
				end else begin
					start     <= 1'b0;
					candidate <= $urandom();
				end
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				if (fault_count < REPORT_LIMIT) begin
					$display("unexpected result: is_prime %0b smallest_factor %0d",
						is_prime, smallest_factor);
				end
				fault_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (is_prime !== want.is_prime || smallest_factor !== want.factor) begin
					if (fault_count < REPORT_LIMIT) begin
						$display("mismatch for %0d: expected is_prime %0b factor %0d, got %0b %0d",
							$signed(want.value), want.is_prime, want.factor,
							is_prime, smallest_factor);
					end
					fault_count++;
				end
				if (want.is_prime) begin
					primes_seen++;
				end else begin
					others_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		logic [tdp_pkg::CAND_W-1:0] directed_values [$];
		int unsigned                gap_by_phase [4];
		candidate_item_t            item;
		directed_values = '{
			32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'd0, 32'd1, 32'd2,
			32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121,
			32'd65535, 32'd65537, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h4000_0001,
			32'h5555_5555, 32'd16_752_649, 32'd16_777_213, 32'd16_777_216
		};
		gap_by_phase = '{0, 78, 0, 30};
		foreach (directed_values[i]) begin
			item.value   = directed_values[i];
			item.gap_pct = 0;
			pending_candidates.push_back(item);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			item.value   = draw_candidate();
			item.gap_pct = gap_by_phase[i * 4 / RANDOM_ITEMS];
			pending_candidates.push_back(item);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do begin
			@(negedge clk);
		end while (pending_candidates.size() != 0 || start || expected_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_verdicts.size() != 0) begin
			$display("%0d results never arrived", expected_verdicts.size());
			fault_count += expected_verdicts.size();
		end

		$display("checked %0d verdicts: %0d prime, %0d composite, negative or below two",
			primes_seen + others_seen, primes_seen, others_seen);
		$display("sender gaps of 0, 78 and 30 percent; %0d mismatches", fault_count);
		if (fault_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
